// ===== hdl/sit_pkg.sv =====
`timescale 1ns / 1ps

package sit_pkg;

  localparam int CROSS_BITS  = 40;
  // Quotient bits kept by the divider: one more than the output range needs.
  localparam int QUO_BITS    = CROSS_BITS + 1;
  localparam int DIV_LAT     = QUO_BITS + 1;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [QUO_BITS-1:0] POS_LIM =
    {{(QUO_BITS-CROSS_BITS+1){1'b0}}, {(CROSS_BITS-1){1'b1}}};
  localparam logic [QUO_BITS-1:0] NEG_LIM = POS_LIM + QUO_BITS'(1);
  localparam logic [CROSS_BITS-1:0] CROSS_MAX = {1'b0, {(CROSS_BITS-1){1'b1}}};
  localparam logic [CROSS_BITS-1:0] CROSS_MIN = {1'b1, {(CROSS_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    KIND_GENERAL   = 3'd0,
    KIND_A_VERT    = 3'd1,
    KIND_B_VERT    = 3'd2,
    KIND_BOTH_VERT = 3'd3,
    KIND_PARALLEL  = 3'd4
  } kind_e;

endpackage

// ===== hdl/sit_fifo.sv =====
`timescale 1ns / 1ps

module sit_fifo import sit_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= PW'(wr_q + PW'(1));
      end
      if (pop_i) begin
        rd_q <= PW'(rd_q + PW'(1));
      end
      if (push_i && !pop_i) begin
        cnt_q <= CW'(cnt_q + CW'(1));
      end else if (pop_i && !push_i) begin
        cnt_q <= CW'(cnt_q - CW'(1));
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");

endmodule

// ===== hdl/sit_front.sv =====
`timescale 1ns / 1ps

module sit_front import sit_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] a_start_x_i,
  input  logic signed [COORD_BITS-1:0] a_start_y_i,
  input  logic signed [COORD_BITS-1:0] a_end_x_i,
  input  logic signed [COORD_BITS-1:0] a_end_y_i,
  input  logic signed [COORD_BITS-1:0] b_start_x_i,
  input  logic signed [COORD_BITS-1:0] b_start_y_i,
  input  logic signed [COORD_BITS-1:0] b_end_x_i,
  input  logic signed [COORD_BITS-1:0] b_end_y_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output kind_e                        kind_o,
  output logic                         sx_o,
  output logic                         sy_o,
  output logic [3*COORD_BITS+4:0]      magx_o,
  output logic [3*COORD_BITS+4:0]      magy_o,
  output logic [2*COORD_BITS+2:0]      dabs_o,
  output logic [4*COORD_BITS-1:0]      bnd_o
);

  localparam int C  = COORD_BITS;
  localparam int DW = 2*C + 3;
  localparam int NW = 3*C + 5;
  localparam int H  = (DW + 1) / 2;
  localparam int PW = 2*C + 4;
  localparam int BW = 4*C;

  logic       en;
  logic [6:0] v_q;

  assign en         = !(v_q[6] && q_full_i);
  assign in_stall_o = !en;
  assign push_o     = v_q[6] && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[5:0], in_valid_i};
    end
  end

  // Stage 1: direction vectors and the common bounding box of both segments
  logic signed [C-1:0] amnx, amxx, bmnx, bmxx, amny, amxy, bmny, bmxy;
  logic signed [C-1:0] lox, hix, loy, hiy;

  always_comb begin
    amnx = (a_start_x_i < a_end_x_i) ? a_start_x_i : a_end_x_i;
    amxx = (a_start_x_i < a_end_x_i) ? a_end_x_i : a_start_x_i;
    bmnx = (b_start_x_i < b_end_x_i) ? b_start_x_i : b_end_x_i;
    bmxx = (b_start_x_i < b_end_x_i) ? b_end_x_i : b_start_x_i;
    amny = (a_start_y_i < a_end_y_i) ? a_start_y_i : a_end_y_i;
    amxy = (a_start_y_i < a_end_y_i) ? a_end_y_i : a_start_y_i;
    bmny = (b_start_y_i < b_end_y_i) ? b_start_y_i : b_end_y_i;
    bmxy = (b_start_y_i < b_end_y_i) ? b_end_y_i : b_start_y_i;
    lox  = (amnx > bmnx) ? amnx : bmnx;
    hix  = (amxx < bmxx) ? amxx : bmxx;
    loy  = (amny > bmny) ? amny : bmny;
    hiy  = (amxy < bmxy) ? amxy : bmxy;
  end

  logic signed [C:0]   adx1_q, ady1_q, bdx1_q, bdy1_q, ebx1_q, eby1_q;
  logic signed [C-1:0] a1x1_q, a1y1_q, b1x1_q, b1y1_q;
  logic [BW-1:0]       bnd_q [7];

  always_ff @(posedge clk_i) begin
    if (en) begin
      adx1_q   <= (C+1)'(a_end_x_i) - (C+1)'(a_start_x_i);
      ady1_q   <= (C+1)'(a_end_y_i) - (C+1)'(a_start_y_i);
      bdx1_q   <= (C+1)'(b_end_x_i) - (C+1)'(b_start_x_i);
      bdy1_q   <= (C+1)'(b_end_y_i) - (C+1)'(b_start_y_i);
      ebx1_q   <= (C+1)'(b_start_x_i) - (C+1)'(a_start_x_i);
      eby1_q   <= (C+1)'(b_start_y_i) - (C+1)'(a_start_y_i);
      a1x1_q   <= a_start_x_i;
      a1y1_q   <= a_start_y_i;
      b1x1_q   <= b_start_x_i;
      b1y1_q   <= b_start_y_i;
      bnd_q[0] <= {lox, hix, loy, hiy};
      for (int i = 1; i < 7; i++) begin
        bnd_q[i] <= bnd_q[i-1];
      end
    end
  end

  // Stage 2: cross products
  logic signed [2*C+1:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [C:0]     adx2_q, ady2_q, bdx2_q, bdy2_q, ebx2_q;
  logic signed [C-1:0]   a1x2_q, a1y2_q, b1x2_q, b1y2_q;
  logic                  av2_q, bv2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q   <= (2*C+2)'(adx1_q) * (2*C+2)'(bdy1_q);
      p2_q   <= (2*C+2)'(ady1_q) * (2*C+2)'(bdx1_q);
      p3_q   <= (2*C+2)'(ebx1_q) * (2*C+2)'(bdy1_q);
      p4_q   <= (2*C+2)'(eby1_q) * (2*C+2)'(bdx1_q);
      av2_q  <= (adx1_q == '0);
      bv2_q  <= (bdx1_q == '0);
      adx2_q <= adx1_q;
      ady2_q <= ady1_q;
      bdx2_q <= bdx1_q;
      bdy2_q <= bdy1_q;
      ebx2_q <= ebx1_q;
      a1x2_q <= a1x1_q;
      a1y2_q <= a1y1_q;
      b1x2_q <= b1x1_q;
      b1y2_q <= b1y1_q;
    end
  end

  // Stage 3: classify and pick the operands of n = p*d + q*c for each axis
  logic signed [DW-1:0] dg, cg, d3, c3;
  logic signed [C-1:0]  px3, py3;
  logic signed [C:0]    qx3, qy3;
  kind_e                kind3;

  always_comb begin
    dg = DW'(p1_q) - DW'(p2_q);
    cg = DW'(p3_q) - DW'(p4_q);
    if (av2_q && bv2_q) begin
      kind3 = KIND_BOTH_VERT;
    end else if (av2_q) begin
      kind3 = KIND_A_VERT;
    end else if (bv2_q) begin
      kind3 = KIND_B_VERT;
    end else if (dg == '0) begin
      kind3 = KIND_PARALLEL;
    end else begin
      kind3 = KIND_GENERAL;
    end
    if (av2_q) begin
      d3  = DW'(bdx2_q);
      c3  = -DW'(ebx2_q);
      px3 = a1x2_q;
      qx3 = '0;
      py3 = b1y2_q;
      qy3 = bdy2_q;
    end else if (bv2_q) begin
      d3  = DW'(adx2_q);
      c3  = DW'(ebx2_q);
      px3 = b1x2_q;
      qx3 = '0;
      py3 = a1y2_q;
      qy3 = ady2_q;
    end else begin
      d3  = dg;
      c3  = cg;
      px3 = a1x2_q;
      qx3 = adx2_q;
      py3 = a1y2_q;
      qy3 = ady2_q;
    end
  end

  logic signed [DW-1:0] d3_q, c3_q;
  logic signed [C-1:0]  px3_q, py3_q;
  logic signed [C:0]    qx3_q, qy3_q;
  kind_e                kind_q [3:6];

  always_ff @(posedge clk_i) begin
    if (en) begin
      d3_q      <= d3;
      c3_q      <= c3;
      px3_q     <= px3;
      py3_q     <= py3;
      qx3_q     <= qx3;
      qy3_q     <= qy3;
      kind_q[3] <= kind3;
      kind_q[4] <= kind_q[3];
      kind_q[5] <= kind_q[4];
      kind_q[6] <= kind_q[5];
    end
  end

  // Stage 4: split d and c into halves so each product stays narrow
  logic signed [PW-1:0] dl, dh, cl, ch;
  logic signed [PW-1:0] pxl_q, pxh_q, qxl_q, qxh_q, pyl_q, pyh_q, qyl_q, qyh_q;
  logic                 dneg_q [4:6];
  logic [DW-1:0]        dabs_q [4:6];

  assign dl = PW'($signed({1'b0, d3_q[H-1:0]}));
  assign dh = PW'($signed(d3_q[DW-1:H]));
  assign cl = PW'($signed({1'b0, c3_q[H-1:0]}));
  assign ch = PW'($signed(c3_q[DW-1:H]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxl_q     <= PW'(px3_q) * dl;
      pxh_q     <= PW'(px3_q) * dh;
      qxl_q     <= PW'(qx3_q) * cl;
      qxh_q     <= PW'(qx3_q) * ch;
      pyl_q     <= PW'(py3_q) * dl;
      pyh_q     <= PW'(py3_q) * dh;
      qyl_q     <= PW'(qy3_q) * cl;
      qyh_q     <= PW'(qy3_q) * ch;
      dneg_q[4] <= d3_q[DW-1];
      dabs_q[4] <= d3_q[DW-1] ? DW'(-d3_q) : DW'(d3_q);
      dneg_q[5] <= dneg_q[4];
      dabs_q[5] <= dabs_q[4];
      dneg_q[6] <= dneg_q[5];
      dabs_q[6] <= dabs_q[5];
    end
  end

  // Stage 5: recombine halves
  logic signed [NW-1:0] tx5_q, ux5_q, ty5_q, uy5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      tx5_q <= (NW'(pxh_q) <<< H) + NW'(pxl_q);
      ux5_q <= (NW'(qxh_q) <<< H) + NW'(qxl_q);
      ty5_q <= (NW'(pyh_q) <<< H) + NW'(pyl_q);
      uy5_q <= (NW'(qyh_q) <<< H) + NW'(qyl_q);
    end
  end

  // Stage 6: numerators
  logic signed [NW-1:0] nx6_q, ny6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx6_q <= tx5_q + ux5_q;
      ny6_q <= ty5_q + uy5_q;
    end
  end

  // Stage 7: sign and magnitude; a negative d flips the sign of the point
  logic              sx7_q, sy7_q;
  logic [NW-1:0]     magx7_q, magy7_q;
  kind_e             kind7_q;
  logic [DW-1:0]     dabs7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx7_q   <= (nx6_q != '0) && (nx6_q[NW-1] ^ dneg_q[6]);
      sy7_q   <= (ny6_q != '0) && (ny6_q[NW-1] ^ dneg_q[6]);
      magx7_q <= nx6_q[NW-1] ? NW'(-nx6_q) : NW'(nx6_q);
      magy7_q <= ny6_q[NW-1] ? NW'(-ny6_q) : NW'(ny6_q);
      kind7_q <= kind_q[6];
      dabs7_q <= dabs_q[6];
    end
  end

  assign kind_o = kind7_q;
  assign sx_o   = sx7_q;
  assign sy_o   = sy7_q;
  assign magx_o = magx7_q;
  assign magy_o = magy7_q;
  assign dabs_o = dabs7_q;
  assign bnd_o  = bnd_q[6];

endmodule

// ===== hdl/sit_div.sv =====
`timescale 1ns / 1ps

module sit_div import sit_pkg::*; #(
  parameter int DW        = 35,
  parameter int NW        = 53,
  parameter int FRAC_BITS = 8
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [NW-1:0]       mag_i,
  input  logic [DW-1:0]       den_i,
  output logic [QUO_BITS-1:0] quo_o,
  output logic [DW-1:0]       rem_o,
  output logic                ovf_o
);

  localparam int MW = NW + FRAC_BITS;
  localparam int MT = (MW > QUO_BITS) ? MW : QUO_BITS + 1;
  localparam int TW = MT - QUO_BITS;
  localparam int CW = (TW > DW) ? TW : DW;

  logic [MT-1:0] mx;
  logic [CW-1:0] top;

  assign mx  = MT'(mag_i) << FRAC_BITS;
  assign top = CW'(mx[MT-1:QUO_BITS]);

  logic [DW-1:0]       rem_q [QUO_BITS+1];
  logic [QUO_BITS-1:0] quo_q [QUO_BITS+1];
  logic                ovf_q [QUO_BITS+1];
  logic [QUO_BITS-1:0] low_q [QUO_BITS];
  logic [DW-1:0]       den_q [QUO_BITS];

  // Upper part at or above d means the quotient needs more than QUO_BITS bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= top[DW-1:0];
      quo_q[0] <= '0;
      ovf_q[0] <= (top >= CW'(den_i));
      low_q[0] <= mx[QUO_BITS-1:0];
      den_q[0] <= den_i;
    end
  end

  for (genvar k = 1; k <= QUO_BITS; k++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;

    assign trial = {rem_q[k-1], low_q[k-1][QUO_BITS-1]};
    assign ge    = (trial >= {1'b0, den_q[k-1]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DW'(trial - {1'b0, den_q[k-1]}) : trial[DW-1:0];
        quo_q[k] <= {quo_q[k-1][QUO_BITS-2:0], ge};
        ovf_q[k] <= ovf_q[k-1];
      end
    end

    if (k < QUO_BITS) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          low_q[k] <= low_q[k-1] << 1;
          den_q[k] <= den_q[k-1];
        end
      end
    end
  end

  assign quo_o = quo_q[QUO_BITS];
  assign rem_o = rem_q[QUO_BITS];
  assign ovf_o = ovf_q[QUO_BITS];

endmodule

// ===== hdl/sit_back.sv =====
`timescale 1ns / 1ps

module sit_back import sit_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         empty_i,
  output logic                         pop_o,
  input  kind_e                        kind_i,
  input  logic                         sx_i,
  input  logic                         sy_i,
  input  logic [3*COORD_BITS+4:0]      magx_i,
  input  logic [3*COORD_BITS+4:0]      magy_i,
  input  logic [2*COORD_BITS+2:0]      dabs_i,
  input  logic [4*COORD_BITS-1:0]      bnd_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o,
  output logic [2:0]                   case_kind_o,
  output logic signed [CROSS_BITS-1:0] cross_x_o,
  output logic signed [CROSS_BITS-1:0] cross_y_o,
  output logic                         saturated_o
);

  localparam int C   = COORD_BITS;
  localparam int DW  = 2*C + 3;
  localparam int NW  = 3*C + 5;
  localparam int SBW = 3 + 2 + 4*C;
  localparam int HW  = QUO_BITS + 2;
  localparam logic [QUO_BITS-1:0] FMASK = {QUO_BITS{1'b1}} >> (QUO_BITS - FRAC_BITS);

  logic en;
  logic out_valid_q;

  assign en    = !(out_valid_q && out_stall_i);
  assign pop_o = en && !empty_i;

  logic [QUO_BITS-1:0] qx, qy;
  logic [DW-1:0]       rx, ry;
  logic                ovx, ovy;

  sit_div #(.DW(DW), .NW(NW), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (magx_i),
    .den_i (dabs_i),
    .quo_o (qx),
    .rem_o (rx),
    .ovf_o (ovx)
  );

  sit_div #(.DW(DW), .NW(NW), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (magy_i),
    .den_i (dabs_i),
    .quo_o (qy),
    .rem_o (ry),
    .ovf_o (ovy)
  );

  // Side data travels alongside the dividers
  logic [DIV_LAT-1:0] vld_q;
  logic [SBW-1:0]     sb_q [DIV_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DIV_LAT-2:0], !empty_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= {kind_i, sx_i, sy_i, bnd_i};
      for (int i = 1; i < DIV_LAT; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
    end
  end

  // Exact box test from floor(|n|/d) and an exactness flag
  function automatic logic axis_in(input logic [QUO_BITS-1:0] q, input logic [DW-1:0] r,
                                   input logic ov, input logic s,
                                   input logic signed [C-1:0] lo,
                                   input logic signed [C-1:0] hi);
    logic signed [HW-1:0] qi, l, u;
    logic                 fz, ge_lo, le_hi;
    qi = $signed(HW'(q >> FRAC_BITS));
    l  = HW'(lo);
    u  = HW'(hi);
    fz = ((q & FMASK) != '0) || (r != '0);
    if (s) begin
      ge_lo = (qi < -l) || ((qi == -l) && !fz);
      le_hi = (qi >= -u);
    end else begin
      ge_lo = (qi >= l);
      le_hi = (qi < u) || ((qi == u) && !fz);
    end
    return !ov && ge_lo && le_hi;
  endfunction

  // Clamp to the output range; the top bit of the result flags a clamp
  function automatic logic [CROSS_BITS:0] fix_val(input logic [QUO_BITS-1:0] q,
                                                  input logic ov, input logic s);
    logic                  sat;
    logic [CROSS_BITS-1:0] v;
    sat = ov || (s ? (q > NEG_LIM) : (q > POS_LIM));
    if (sat) begin
      v = s ? CROSS_MIN : CROSS_MAX;
    end else begin
      v = s ? (~q[CROSS_BITS-1:0] + 1'b1) : q[CROSS_BITS-1:0];
    end
    return {sat, v};
  endfunction

  logic [SBW-1:0]        sbl;
  kind_e                 kind;
  logic                  sx, sy, has_pt, hx, hy;
  logic signed [C-1:0]   lox, hix, loy, hiy;
  logic [CROSS_BITS:0]   fx, fy;

  always_comb begin
    sbl    = sb_q[DIV_LAT-1];
    kind   = kind_e'(sbl[SBW-1 -: 3]);
    sx     = sbl[4*C+1];
    sy     = sbl[4*C];
    lox    = $signed(sbl[4*C-1 -: C]);
    hix    = $signed(sbl[3*C-1 -: C]);
    loy    = $signed(sbl[2*C-1 -: C]);
    hiy    = $signed(sbl[C-1 -: C]);
    has_pt = (kind == KIND_GENERAL) || (kind == KIND_A_VERT) || (kind == KIND_B_VERT);
    hx     = axis_in(qx, rx, ovx, sx, lox, hix);
    hy     = axis_in(qy, ry, ovy, sy, loy, hiy);
    fx     = fix_val(qx, ovx, sx);
    fy     = fix_val(qy, ovy, sy);
  end

  logic                  hit_q, sat_q;
  logic [2:0]            kind_q;
  logic [CROSS_BITS-1:0] cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= has_pt && hx && hy;
      kind_q <= kind;
      cx_q   <= has_pt ? fx[CROSS_BITS-1:0] : '0;
      cy_q   <= has_pt ? fy[CROSS_BITS-1:0] : '0;
      sat_q  <= has_pt && (fx[CROSS_BITS] || fy[CROSS_BITS]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign case_kind_o = kind_q;
  assign cross_x_o   = $signed(cx_q);
  assign cross_y_o   = $signed(cy_q);
  assign saturated_o = sat_q;

  a_no_point_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q == KIND_BOTH_VERT || kind_q == KIND_PARALLEL))
      |-> (cx_q == '0 && cy_q == '0 && !hit_q && !sat_q))
    else $error("result without a crossing carries nonzero fields");
  a_hit_unclamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && hit_q) |-> !sat_q)
    else $error("hit reported on a clamped point");

endmodule

// ===== hdl/segment_intersection_test.sv =====
`timescale 1ns / 1ps

// Takes one pair of segments per cycle while in_stall_o is low and returns
// one result per pair, in order. An item passes through the front end
// (differences, cross products, case selection, split products,
// recombination, numerators, sign), the 4-entry queue, the dividers and
// the output register. Throughput is one pair per clock when nothing
// stalls, set by the two fully pipelined dividers that retire one quotient
// bit per stage. Output stalls freeze the divider pipeline; the front end
// keeps accepting until the queue is full and its own last stage is valid.
module segment_intersection_test import sit_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] a_start_x_i,
  input  logic signed [COORD_BITS-1:0] a_start_y_i,
  input  logic signed [COORD_BITS-1:0] a_end_x_i,
  input  logic signed [COORD_BITS-1:0] a_end_y_i,
  input  logic signed [COORD_BITS-1:0] b_start_x_i,
  input  logic signed [COORD_BITS-1:0] b_start_y_i,
  input  logic signed [COORD_BITS-1:0] b_end_x_i,
  input  logic signed [COORD_BITS-1:0] b_end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o,
  output logic [2:0]                   case_kind_o,
  output logic signed [CROSS_BITS-1:0] cross_x_o,
  output logic signed [CROSS_BITS-1:0] cross_y_o,
  output logic                         saturated_o
);

  localparam int C  = COORD_BITS;
  localparam int DW = 2*C + 3;
  localparam int NW = 3*C + 5;
  localparam int EW = 3 + 2 + 2*NW + DW + 4*C;

  logic          push, full, pop, empty;
  kind_e         f_kind, b_kind;
  logic          f_sx, f_sy, b_sx, b_sy;
  logic [NW-1:0] f_magx, f_magy, b_magx, b_magy;
  logic [DW-1:0] f_dabs, b_dabs;
  logic [4*C-1:0] f_bnd, b_bnd;
  logic [EW-1:0] q_in, q_out;

  sit_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .a_start_x_i (a_start_x_i),
    .a_start_y_i (a_start_y_i),
    .a_end_x_i   (a_end_x_i),
    .a_end_y_i   (a_end_y_i),
    .b_start_x_i (b_start_x_i),
    .b_start_y_i (b_start_y_i),
    .b_end_x_i   (b_end_x_i),
    .b_end_y_i   (b_end_y_i),
    .q_full_i    (full),
    .push_o      (push),
    .kind_o      (f_kind),
    .sx_o        (f_sx),
    .sy_o        (f_sy),
    .magx_o      (f_magx),
    .magy_o      (f_magy),
    .dabs_o      (f_dabs),
    .bnd_o       (f_bnd)
  );

  assign q_in = {f_kind, f_sx, f_sy, f_magx, f_magy, f_dabs, f_bnd};

  sit_fifo #(.WIDTH(EW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_out)
  );

  assign b_kind = kind_e'(q_out[EW-1 -: 3]);
  assign b_sx   = q_out[EW-4];
  assign b_sy   = q_out[EW-5];
  assign b_magx = q_out[EW-6 -: NW];
  assign b_magy = q_out[EW-6-NW -: NW];
  assign b_dabs = q_out[4*C+DW-1 -: DW];
  assign b_bnd  = q_out[4*C-1:0];

  sit_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .kind_i      (b_kind),
    .sx_i        (b_sx),
    .sy_i        (b_sy),
    .magx_i      (b_magx),
    .magy_i      (b_magy),
    .dabs_i      (b_dabs),
    .bnd_i       (b_bnd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hit_o       (hit_o),
    .case_kind_o (case_kind_o),
    .cross_x_o   (cross_x_o),
    .cross_y_o   (cross_y_o),
    .saturated_o (saturated_o)
  );

endmodule
